>>> hw/rtl/i2cm_pkg.sv
// Shared constants, types and codes for the I2C bit-level master.
package i2cm_pkg;

    // Slot counter width default and configuration register width
    localparam int SLOT_WIDTH_DEF = 16;
    localparam int CFG_W          = 16;
    localparam logic [CFG_W-1:0] SLOT_TICKS_RST = 16'd10;

    // Field widths
    localparam int MODE_W = 3;
    localparam int BYTE_W = 8;
    localparam int BIT_W  = 4;
    localparam int ERR_W  = 2;

    // Tick queue between front and engine
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Bit counts used by the sequencer
    localparam logic [BIT_W-1:0] BITS_PER_BYTE   = 4'd8;
    localparam logic [BIT_W-1:0] STOP_IDLE_SLOTS = 4'd4;

    // Command codes
    typedef enum logic [MODE_W-1:0] {
        MODE_START   = 3'd0,
        MODE_RESTART = 3'd1,
        MODE_STOP    = 3'd2,
        MODE_WRITE   = 3'd3,
        MODE_READ    = 3'd4
    } t_mode;

    // Sequencer phases
    typedef enum logic [4:0] {
        PH_IDLE       = 5'd0,
        PH_ST1        = 5'd1,
        PH_ST2        = 5'd2,
        PH_RS1        = 5'd3,
        PH_RS2        = 5'd4,
        PH_RS3        = 5'd5,
        PH_RS4        = 5'd6,
        PH_SP1        = 5'd7,
        PH_SP2        = 5'd8,
        PH_SP3        = 5'd9,
        PH_SP4        = 5'd10,
        PH_SP5        = 5'd11,
        PH_WR_HI      = 5'd12,
        PH_WR_LO      = 5'd13,
        PH_WR_ACKHI   = 5'd14,
        PH_WR_ACKSAMP = 5'd15,
        PH_RD_SAMP    = 5'd16,
        PH_RD_NEXT    = 5'd17,
        PH_RD_ACKHI   = 5'd18,
        PH_RD_ACKLO   = 5'd19,
        PH_RD_REL     = 5'd20
    } t_phase;

    // One classified tick as held in the queue
    typedef struct packed {
        logic              take;
        t_mode             mode;
        logic [BYTE_W-1:0] tx_byte;
        logic              last_read;
        logic              sda_level;
        logic              scl_level;
    } t_tick;

endpackage

>>> hw/rtl/i2cm_if.sv
// Channel interfaces: tick input, result output and configuration write.
interface i2cm_cmd_if;
    logic                         valid;
    logic                         ready;
    logic                         cmd_valid;
    logic [i2cm_pkg::MODE_W-1:0]  mode;
    logic [i2cm_pkg::BYTE_W-1:0]  tx_byte;
    logic                         last_read;
    logic                         sda_level;
    logic                         scl_level;

    modport source (output valid, cmd_valid, mode, tx_byte, last_read, sda_level, scl_level,
                    input ready);
    modport sink   (input valid, cmd_valid, mode, tx_byte, last_read, sda_level, scl_level,
                    output ready);
endinterface

interface i2cm_res_if;
    logic                         valid;
    logic                         ready;
    logic                         scl_pull_low;
    logic                         sda_pull_low;
    logic                         ready_res;
    logic                         done_res;
    logic [i2cm_pkg::BYTE_W-1:0]  rx_byte;
    logic                         ack_seen;
    logic [i2cm_pkg::ERR_W-1:0]   low_line_count;

    modport source (output valid, scl_pull_low, sda_pull_low, ready_res, done_res, rx_byte,
                    ack_seen, low_line_count, input ready);
    modport sink   (input valid, scl_pull_low, sda_pull_low, ready_res, done_res, rx_byte,
                    ack_seen, low_line_count, output ready);
endinterface

interface i2cm_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [i2cm_pkg::CFG_W-1:0]  slot_ticks;

    modport source (output valid, slot_ticks, input ready);
    modport sink   (input valid, slot_ticks, output ready);
endinterface

>>> hw/rtl/i2c_bit_level_master.sv
// I2C bit-level master: one tick beat in, one result beat out.
// Throughput: one tick per clock cycle unless result-side stalls hold the engine.
// A tick passes through a queue slot, then its result beat through the output register;
// stalls on the result side back up the 4-deep tick queue.
// Reset: synchronous, active low; bus released, sequencer idle, slot length 10 ticks.
// No clearing pass is needed: the block takes ticks from the first cycle after reset.
module i2c_bit_level_master #(
    parameter int SLOT_WIDTH = i2cm_pkg::SLOT_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    i2cm_cmd_if.sink   i_cmd,
    i2cm_cfg_if.sink   i_cfg,
    i2cm_res_if.source o_res
);
    import i2cm_pkg::*;

    logic  w_full;
    logic  w_push;
    logic  w_q_valid;
    logic  w_pop;
    t_tick w_in_tick;
    t_tick w_q_tick;

    // Classify incoming ticks
    i2cm_front u_front (
        .i_cmd  (i_cmd),
        .i_full (w_full),
        .o_push (w_push),
        .o_tick (w_in_tick)
    );

    // Decouple front and engine
    i2cm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_tick  (w_in_tick),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_tick  (w_q_tick),
        .i_pop   (w_pop)
    );

    // Step the bus sequencer
    i2cm_engine #(
        .SLOT_WIDTH (SLOT_WIDTH)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .i_valid (w_q_valid),
        .i_tick  (w_q_tick),
        .o_pop   (w_pop),
        .o_res   (o_res)
    );

endmodule

>>> hw/rtl/i2cm_front.sv
// Front end: takes tick beats and classifies the offered command.
module i2cm_front (
    i2cm_cmd_if.sink        i_cmd,
    input  logic            i_full,
    output logic            o_push,
    output i2cm_pkg::t_tick o_tick
);
    import i2cm_pkg::*;

    // Accept whenever the queue has room
    assign i_cmd.ready = ~i_full;
    assign o_push      = i_cmd.valid & ~i_full;

    // Decode the command; unknown codes are never taken
    always_comb begin
        o_tick.take      = 1'b0;
        o_tick.mode      = MODE_START;
        o_tick.tx_byte   = i_cmd.tx_byte;
        o_tick.last_read = i_cmd.last_read;
        o_tick.sda_level = i_cmd.sda_level;
        o_tick.scl_level = i_cmd.scl_level;
        unique case (i_cmd.mode) inside
            MODE_START, MODE_RESTART, MODE_STOP, MODE_WRITE, MODE_READ: begin
                o_tick.take = i_cmd.cmd_valid;
                o_tick.mode = t_mode'(i_cmd.mode);
            end
            default: begin
                o_tick.take = 1'b0;
            end
        endcase
    end

endmodule

>>> hw/rtl/i2cm_queue.sv
// Short tick queue between the front end and the bus engine.
module i2cm_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  i2cm_pkg::t_tick i_tick,
    output logic            o_full,
    output logic            o_valid,
    output i2cm_pkg::t_tick o_tick,
    input  logic            i_pop
);
    import i2cm_pkg::*;

    t_tick              r_slot [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_tick  = r_slot[r_rd_ptr];

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wr_ptr] <= i_tick;
    end

endmodule

>>> hw/rtl/i2cm_engine.sv
// Bus engine: steps the sequencer once per tick and registers the result beat.
module i2cm_engine #(
    parameter int SLOT_WIDTH = i2cm_pkg::SLOT_WIDTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    i2cm_cfg_if.sink        i_cfg,
    input  logic            i_valid,
    input  i2cm_pkg::t_tick i_tick,
    output logic            o_pop,
    i2cm_res_if.source      o_res
);
    import i2cm_pkg::*;

    // Configuration and sequencer state
    logic [CFG_W-1:0]      r_slot_ticks;
    t_phase                r_phase,   n_phase;
    logic [BIT_W-1:0]      r_bit,     n_bit;
    logic [SLOT_WIDTH-1:0] r_cnt,     n_cnt;
    logic [BYTE_W-1:0]     r_shift,   n_shift;
    logic                  r_scl,     n_scl;
    logic                  r_sda,     n_sda;
    logic                  r_nack,    n_nack;
    logic [BYTE_W-1:0]     r_rx,      n_rx;
    logic                  r_ack,     n_ack;
    logic [ERR_W-1:0]      r_err,     n_err;
    logic                  r_out_valid;

    logic [SLOT_WIDTH-1:0] w_slot_raw;
    logic [SLOT_WIDTH-1:0] w_slot_load;
    logic [SLOT_WIDTH-1:0] w_cnt_dec;
    logic                  w_fire;
    logic                  w_reload;
    logic                  w_done;
    logic [BIT_W-1:0]      w_bit_inc;

    // Configuration port never stalls
    assign i_cfg.ready = 1'b1;

    // Take the next tick whenever the output register is free or draining
    assign o_pop = i_valid & (~r_out_valid | o_res.ready);

    // Slot reload value: register fitted to the counter width, zero acts as one
    always_comb begin
        w_slot_raw = '0;
        for (int i = 0; i < SLOT_WIDTH && i < CFG_W; i++) begin
            w_slot_raw[i] = r_slot_ticks[i];
        end
        w_slot_load = (w_slot_raw == '0) ? SLOT_WIDTH'(1) : w_slot_raw;
    end

    assign w_cnt_dec = (r_cnt != '0) ? r_cnt - 1'b1 : '0;
    assign w_fire    = (w_cnt_dec == '0);
    assign w_bit_inc = r_bit + 1'b1;

    // Next phase and slot reload
    always_comb begin
        n_phase  = r_phase;
        w_reload = 1'b0;
        if (r_phase == PH_IDLE) begin
            if (i_tick.take) begin
                w_reload = 1'b1;
                unique case (i_tick.mode)
                    MODE_START:   n_phase = PH_ST1;
                    MODE_RESTART: n_phase = PH_RS1;
                    MODE_STOP:    n_phase = PH_SP1;
                    MODE_WRITE:   n_phase = PH_WR_HI;
                    MODE_READ:    n_phase = PH_RD_SAMP;
                    default:      n_phase = r_phase;
                endcase
            end
        end else if (w_fire) begin
            w_reload = 1'b1;
            unique case (r_phase)
                PH_ST1:      n_phase = PH_ST2;
                PH_RS1:      n_phase = PH_RS2;
                PH_RS2:      n_phase = PH_RS3;
                PH_RS3:      n_phase = PH_RS4;
                PH_SP1:      n_phase = PH_SP2;
                PH_SP2:      n_phase = PH_SP3;
                PH_SP3:      n_phase = PH_SP4;
                PH_SP4:      n_phase = PH_SP5;
                PH_SP5: begin
                    if (w_bit_inc >= STOP_IDLE_SLOTS) begin
                        n_phase  = PH_IDLE;
                        w_reload = 1'b0;
                    end
                end
                PH_WR_HI:    n_phase = PH_WR_LO;
                PH_WR_LO:    n_phase = (w_bit_inc < BITS_PER_BYTE) ? PH_WR_HI : PH_WR_ACKHI;
                PH_WR_ACKHI: n_phase = PH_WR_ACKSAMP;
                PH_RD_SAMP:  n_phase = PH_RD_NEXT;
                PH_RD_NEXT:  n_phase = (r_bit < BITS_PER_BYTE) ? PH_RD_SAMP : PH_RD_ACKHI;
                PH_RD_ACKHI: n_phase = PH_RD_ACKLO;
                PH_RD_ACKLO: n_phase = PH_RD_REL;
                default: begin
                    // end of start, repeated start, write ACK sample, read release
                    n_phase  = PH_IDLE;
                    w_reload = 1'b0;
                end
            endcase
        end
    end

    // Line drives, shift register, counters and flags
    always_comb begin
        n_bit   = r_bit;
        n_shift = r_shift;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_nack  = r_nack;
        n_rx    = r_rx;
        n_ack   = r_ack;
        n_err   = r_err;
        if (w_reload)               n_cnt = w_slot_load;
        else if (r_phase != PH_IDLE) n_cnt = w_cnt_dec;
        else                         n_cnt = r_cnt;

        if (r_phase == PH_IDLE) begin
            if (i_tick.take) begin
                unique case (i_tick.mode)
                    MODE_START:   n_sda = 1'b1;
                    MODE_RESTART: n_sda = 1'b0;
                    MODE_STOP:    n_scl = 1'b1;
                    MODE_WRITE: begin
                        n_shift = i_tick.tx_byte;
                        n_bit   = '0;
                        n_sda   = ~i_tick.tx_byte[BYTE_W-1];
                    end
                    MODE_READ: begin
                        n_nack  = i_tick.last_read;
                        n_shift = '0;
                        n_bit   = '0;
                        n_sda   = 1'b0;
                        n_scl   = 1'b0;
                    end
                    default: n_sda = r_sda;
                endcase
            end
        end else if (w_fire) begin
            unique case (r_phase)
                PH_ST1: n_scl = 1'b1;
                PH_RS1: n_scl = 1'b0;
                PH_RS2: n_sda = 1'b1;
                PH_RS3: n_scl = 1'b1;
                PH_SP1: n_sda = 1'b1;
                PH_SP2: n_scl = 1'b0;
                PH_SP3: n_sda = 1'b0;
                PH_SP4: begin
                    // count lines found low after the stop
                    n_err = {1'b0, ~i_tick.scl_level} + {1'b0, ~i_tick.sda_level};
                    n_bit = '0;
                end
                PH_SP5: n_bit = w_bit_inc;
                PH_WR_HI: n_scl = 1'b0;
                PH_WR_LO: begin
                    n_scl   = 1'b1;
                    n_shift = {r_shift[BYTE_W-2:0], 1'b0};
                    n_bit   = w_bit_inc;
                    n_sda   = (w_bit_inc < BITS_PER_BYTE) ? ~r_shift[BYTE_W-2] : 1'b0;
                end
                PH_WR_ACKHI: n_scl = 1'b0;
                PH_WR_ACKSAMP: begin
                    n_ack = ~i_tick.sda_level;
                    n_scl = 1'b1;
                end
                PH_RD_SAMP: begin
                    n_shift = {r_shift[BYTE_W-2:0], i_tick.sda_level};
                    n_scl   = 1'b1;
                    n_bit   = w_bit_inc;
                end
                PH_RD_NEXT: begin
                    if (r_bit < BITS_PER_BYTE) n_scl = 1'b0;
                    else                       n_sda = ~r_nack;
                end
                PH_RD_ACKHI: n_scl = 1'b0;
                PH_RD_ACKLO: n_scl = 1'b1;
                PH_RD_REL: begin
                    n_sda = 1'b0;
                    n_rx  = r_shift;
                end
                default: n_scl = r_scl;
            endcase
        end
    end

    assign w_done = (r_phase != PH_IDLE) & w_fire & (n_phase == PH_IDLE);

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_ticks <= SLOT_TICKS_RST;
        end else if (i_cfg.valid) begin
            r_slot_ticks <= i_cfg.slot_ticks;
        end
    end

    // Sequencer state advances once per tick taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_bit   <= '0;
            r_cnt   <= '0;
            r_shift <= '0;
            r_scl   <= 1'b0;
            r_sda   <= 1'b0;
            r_nack  <= 1'b0;
            r_rx    <= '0;
            r_ack   <= 1'b0;
            r_err   <= '0;
        end else if (o_pop) begin
            r_phase <= n_phase;
            r_bit   <= n_bit;
            r_cnt   <= n_cnt;
            r_shift <= n_shift;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
            r_nack  <= n_nack;
            r_rx    <= n_rx;
            r_ack   <= n_ack;
            r_err   <= n_err;
        end
    end

    // Result beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            o_res.scl_pull_low   <= n_scl;
            o_res.sda_pull_low   <= n_sda;
            o_res.ready_res      <= (n_phase == PH_IDLE);
            o_res.done_res       <= w_done;
            o_res.rx_byte        <= n_rx;
            o_res.ack_seen       <= n_ack;
            o_res.low_line_count <= n_err;
        end
    end

    assign o_res.valid = r_out_valid;

endmodule

>>> verif/tb_i2c_bit_level_master.sv
// Self-checking testbench for the tick-stepped I2C bit-level master.
`timescale 1ns / 100ps

module tb_i2c_bit_level_master;

    import i2cm_pkg::*;

    localparam int SLOT_W      = SLOT_WIDTH_DEF;
    localparam int CYCLE_LIMIT = 100_000;

    // One tick as offered on the command channel
    typedef struct packed {
        logic              cmd_valid;
        logic [MODE_W-1:0] mode;
        logic [BYTE_W-1:0] tx_byte;
        logic              last_read;
        logic              sda_level;
        logic              scl_level;
    } t_tick_in;

    // One result beat: bus drives and status after a tick
    typedef struct packed {
        logic              scl_low;
        logic              sda_low;
        logic              idle;
        logic              done;
        logic [BYTE_W-1:0] rx;
        logic              ack;
        logic [ERR_W-1:0]  lows;
    } t_beat;

    // Bus sequencer predictor and the queue of bus states it expects
    class i2cm_bus_scoreboard;
        t_phase            ph;
        logic [MODE_W-1:0] act_mode;
        logic [BIT_W-1:0]  bit_cnt;
        logic [31:0]       slot_cnt;
        logic [BYTE_W-1:0] shreg;
        logic              scl_drv;
        logic              sda_drv;
        logic              nack_pend;
        logic [BYTE_W-1:0] rx_hold;
        logic              ack_hold;
        logic [ERR_W-1:0]  err_hold;
        logic [CFG_W-1:0]  slot_len;
        t_beat             expected_beats[$];
        int unsigned       n_ticks;
        int unsigned       n_beats;
        int unsigned       n_errors;
        int unsigned       n_done;
        int unsigned       cmd_taken[5];

        function new();
            ph        = PH_IDLE;
            act_mode  = '0;
            bit_cnt   = '0;
            slot_cnt  = '0;
            shreg     = '0;
            scl_drv   = 1'b0;
            sda_drv   = 1'b0;
            nack_pend = 1'b0;
            rx_hold   = '0;
            ack_hold  = 1'b0;
            err_hold  = '0;
            slot_len  = SLOT_TICKS_RST;
            n_ticks   = 0;
            n_beats   = 0;
            n_errors  = 0;
            n_done    = 0;
            foreach (cmd_taken[i]) cmd_taken[i] = 0;
        endfunction

        function void set_slot(logic [CFG_W-1:0] v);
            slot_len = v;
        endfunction

        function bit seq_idle();
            return ph == PH_IDLE;
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction

        // slot length cut to the counter width; zero behaves as one
        function void reload();
            logic [63:0] t;
            t = 64'(slot_len) & ((64'd1 << SLOT_W) - 64'd1);
            slot_cnt = (t == 64'd0) ? 32'd1 : t[31:0];
        endfunction

        function void enter(t_phase nxt);
            ph = nxt;
            reload();
        endfunction

        // advance one tick and queue the resulting bus state
        function void note_tick(t_tick_in t);
            logic  fin;
            t_beat b;
            fin = 1'b0;
            n_ticks++;
            if (ph == PH_IDLE) begin
                if (t.cmd_valid && t.mode <= MODE_READ) begin
                    act_mode = t.mode;
                    cmd_taken[t.mode]++;
                    case (t.mode)
                        MODE_START: begin
                            sda_drv = 1'b1;
                            enter(PH_ST1);
                        end
                        MODE_RESTART: begin
                            sda_drv = 1'b0;
                            enter(PH_RS1);
                        end
                        MODE_STOP: begin
                            scl_drv = 1'b1;
                            enter(PH_SP1);
                        end
                        MODE_WRITE: begin
                            shreg   = t.tx_byte;
                            bit_cnt = '0;
                            sda_drv = ~shreg[7];
                            enter(PH_WR_HI);
                        end
                        default: begin
                            nack_pend = t.last_read;
                            shreg     = '0;
                            bit_cnt   = '0;
                            sda_drv   = 1'b0;
                            scl_drv   = 1'b0;
                            enter(PH_RD_SAMP);
                        end
                    endcase
                end
            end else begin
                if (slot_cnt != 0) slot_cnt--;
                if (slot_cnt == 0) begin
                    case (ph)
                        PH_ST1: begin scl_drv = 1'b1; enter(PH_ST2); end
                        PH_RS1: begin scl_drv = 1'b0; enter(PH_RS2); end
                        PH_RS2: begin sda_drv = 1'b1; enter(PH_RS3); end
                        PH_RS3: begin scl_drv = 1'b1; enter(PH_RS4); end
                        PH_SP1: begin sda_drv = 1'b1; enter(PH_SP2); end
                        PH_SP2: begin scl_drv = 1'b0; enter(PH_SP3); end
                        PH_SP3: begin sda_drv = 1'b0; enter(PH_SP4); end
                        PH_SP4: begin
                            // frame error count: lines found low at the stop
                            err_hold = {1'b0, ~t.scl_level} + {1'b0, ~t.sda_level};
                            bit_cnt  = '0;
                            enter(PH_SP5);
                        end
                        PH_SP5: begin
                            bit_cnt = bit_cnt + 1'b1;
                            if (bit_cnt >= STOP_IDLE_SLOTS) begin
                                ph  = PH_IDLE;
                                fin = 1'b1;
                            end else begin
                                reload();
                            end
                        end
                        PH_WR_HI: begin scl_drv = 1'b0; enter(PH_WR_LO); end
                        PH_WR_LO: begin
                            scl_drv = 1'b1;
                            shreg   = {shreg[BYTE_W-2:0], 1'b0};
                            bit_cnt = bit_cnt + 1'b1;
                            if (bit_cnt < BITS_PER_BYTE) begin
                                sda_drv = ~shreg[7];
                                enter(PH_WR_HI);
                            end else begin
                                sda_drv = 1'b0;
                                enter(PH_WR_ACKHI);
                            end
                        end
                        PH_WR_ACKHI: begin scl_drv = 1'b0; enter(PH_WR_ACKSAMP); end
                        PH_WR_ACKSAMP: begin
                            ack_hold = ~t.sda_level;
                            scl_drv  = 1'b1;
                            ph       = PH_IDLE;
                            fin      = 1'b1;
                        end
                        PH_RD_SAMP: begin
                            shreg   = {shreg[BYTE_W-2:0], t.sda_level};
                            scl_drv = 1'b1;
                            bit_cnt = bit_cnt + 1'b1;
                            enter(PH_RD_NEXT);
                        end
                        PH_RD_NEXT: begin
                            if (bit_cnt < BITS_PER_BYTE) begin
                                scl_drv = 1'b0;
                                enter(PH_RD_SAMP);
                            end else begin
                                sda_drv = ~nack_pend;
                                enter(PH_RD_ACKHI);
                            end
                        end
                        PH_RD_ACKHI: begin scl_drv = 1'b0; enter(PH_RD_ACKLO); end
                        PH_RD_ACKLO: begin scl_drv = 1'b1; enter(PH_RD_REL); end
                        PH_RD_REL: begin
                            sda_drv = 1'b0;
                            rx_hold = shreg;
                            ph      = PH_IDLE;
                            fin     = 1'b1;
                        end
                        default: begin
                            // end of start and repeated start
                            ph  = PH_IDLE;
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            if (fin) n_done++;
            b.scl_low = scl_drv;
            b.sda_low = sda_drv;
            b.idle    = (ph == PH_IDLE);
            b.done    = fin;
            b.rx      = rx_hold;
            b.ack     = ack_hold;
            b.lows    = err_hold;
            expected_beats.push_back(b);
        endfunction

        task report_mismatch(string msg);
            n_errors++;
            $display("MISMATCH at beat %0d: %s", n_beats, msg);
        endtask

        task compare_field(string name, logic [7:0] got, logic [7:0] exp);
            if (got !== exp)
                report_mismatch($sformatf("%s got %0h expected %0h", name, got, exp));
        endtask

        task check_beat(t_beat got);
            t_beat exp;
            n_beats++;
            if (expected_beats.size() == 0) begin
                report_mismatch("result beat with nothing expected");
                return;
            end
            exp = expected_beats.pop_front();
            compare_field("scl_pull_low", 8'(got.scl_low), 8'(exp.scl_low));
            compare_field("sda_pull_low", 8'(got.sda_low), 8'(exp.sda_low));
            compare_field("ready_res", 8'(got.idle), 8'(exp.idle));
            compare_field("done_res", 8'(got.done), 8'(exp.done));
            compare_field("rx_byte", got.rx, exp.rx);
            compare_field("ack_seen", 8'(got.ack), 8'(exp.ack));
            compare_field("low_line_count", 8'(got.lows), 8'(exp.lows));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    i2cm_cmd_if cmd_ch ();
    i2cm_cfg_if cfg_ch ();
    i2cm_res_if res_ch ();

    i2c_bit_level_master #(
        .SLOT_WIDTH(SLOT_W)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    i2cm_bus_scoreboard sb;

    bit          gaps_on;
    bit          hold_pins;
    logic        hold_sda;
    logic        hold_scl;
    int unsigned cmds_offered;
    int unsigned cfg_writes;
    int unsigned cycles = 0;
    int unsigned stall_left = 0;

    // Clock, 4 ns period
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    // Result side back-pressure in bursts
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left   <= stall_left - 1;
            res_ch.ready <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 9) == 0) begin
            stall_left   <= $urandom_range(0, 5);
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        t_beat got;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got.scl_low = res_ch.scl_pull_low;
            got.sda_low = res_ch.sda_pull_low;
            got.idle    = res_ch.ready_res;
            got.done    = res_ch.done_res;
            got.rx      = res_ch.rx_byte;
            got.ack     = res_ch.ack_seen;
            got.lows    = res_ch.low_line_count;
            sb.check_beat(got);
        end
    end

    function automatic t_tick_in make_tick(logic cv, logic [MODE_W-1:0] m,
                                           logic [BYTE_W-1:0] tx, logic last);
        t_tick_in t;
        t.cmd_valid = cv;
        t.mode      = m;
        t.tx_byte   = tx;
        t.last_read = last;
        t.sda_level = hold_pins ? hold_sda : 1'($urandom_range(0, 1));
        t.scl_level = hold_pins ? hold_scl : 1'($urandom_range(0, 1));
        return t;
    endfunction

    // tick while the sequencer works: commands offered now and then are ignored
    function automatic t_tick_in busy_tick();
        return make_tick(($urandom_range(0, 5) == 0), 3'($urandom_range(0, 7)),
                         8'($urandom), 1'($urandom_range(0, 1)));
    endfunction

    function automatic t_tick_in quiet_tick();
        return make_tick(1'b0, 3'($urandom_range(0, 7)), 8'($urandom),
                         1'($urandom_range(0, 1)));
    endfunction

    // offer one tick beat and wait for it to be taken
    task automatic send_tick(input t_tick_in t);
        int n;
        if (gaps_on && $urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 6);
            cmd_ch.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.cmd_valid <= t.cmd_valid;
        cmd_ch.mode      <= t.mode;
        cmd_ch.tx_byte   <= t.tx_byte;
        cmd_ch.last_read <= t.last_read;
        cmd_ch.sda_level <= t.sda_level;
        cmd_ch.scl_level <= t.scl_level;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        sb.note_tick(t);
    endtask

    // hold off ticks until every expected beat is back
    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // one command, then ticks until the sequencer is idle again
    task automatic issue_cmd(input logic [MODE_W-1:0] m, input logic [BYTE_W-1:0] tx,
                             input logic last);
        cmds_offered++;
        send_tick(make_tick(1'b1, m, tx, last));
        while (!sb.seq_idle()) begin
            if ($urandom_range(0, 399) == 0) drain_results();
            send_tick(busy_tick());
        end
        repeat ($urandom_range(0, 2)) send_tick(quiet_tick());
    endtask

    task automatic write_slot(input logic [CFG_W-1:0] v);
        drain_results();
        cfg_ch.valid      <= 1'b1;
        cfg_ch.slot_ticks <= v;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        sb.set_slot(v);
        cfg_writes++;
    endtask

    task automatic set_pins(input logic sda, input logic scl);
        hold_pins = 1'b1;
        hold_sda  = sda;
        hold_scl  = scl;
    endtask

    // mostly well-formed frames, some stray or broken ones
    task automatic random_transaction();
        int  nbytes;
        bit  reading;
        if ($urandom_range(0, 6) == 0) begin
            issue_cmd(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom_range(0, 1)));
            return;
        end
        issue_cmd(MODE_START, 8'($urandom), 1'($urandom_range(0, 1)));
        issue_cmd(MODE_WRITE, 8'($urandom), 1'($urandom_range(0, 1)));
        nbytes  = $urandom_range(1, 3);
        reading = $urandom_range(0, 1);
        for (int i = 0; i < nbytes; i++) begin
            if (reading)
                issue_cmd(MODE_READ, 8'($urandom),
                          (i == nbytes - 1) ^ ($urandom_range(0, 7) == 0));
            else
                issue_cmd(MODE_WRITE, 8'($urandom), 1'($urandom_range(0, 1)));
        end
        if ($urandom_range(0, 3) == 0) begin
            issue_cmd(MODE_RESTART, 8'($urandom), 1'($urandom_range(0, 1)));
            issue_cmd(MODE_WRITE, 8'($urandom), 1'($urandom_range(0, 1)));
            issue_cmd(MODE_READ, 8'($urandom), 1'b1);
        end
        if ($urandom_range(0, 7) != 0) issue_cmd(MODE_STOP, 8'($urandom), 1'b0);
    endtask

    task automatic random_phase(input logic [CFG_W-1:0] slot, input int unsigned n_cmds);
        int unsigned stop_at;
        write_slot(slot);
        stop_at = cmds_offered + n_cmds;
        while (cmds_offered < stop_at) begin
            random_transaction();
            if ($urandom_range(0, 29) == 0) drain_results();
        end
    endtask

    initial begin
        sb           = new();
        gaps_on      = 1'b1;
        hold_pins    = 1'b0;
        hold_sda     = 1'b1;
        hold_scl     = 1'b1;
        cmds_offered = 0;
        cfg_writes   = 0;

        i_rst_n           <= 1'b0;
        cmd_ch.valid      <= 1'b0;
        cmd_ch.cmd_valid  <= 1'b0;
        cmd_ch.mode       <= MODE_START;
        cmd_ch.tx_byte    <= '0;
        cmd_ch.last_read  <= 1'b0;
        cmd_ch.sda_level  <= 1'b1;
        cmd_ch.scl_level  <= 1'b1;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.slot_ticks <= '0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset slot length on a start
        set_pins(1'b1, 1'b1);
        issue_cmd(MODE_START, 8'h00, 1'b0);

        // ACK and NACK, byte extremes, error counts on a short slot
        write_slot(16'd1);
        issue_cmd(MODE_WRITE, 8'hFF, 1'b0);
        set_pins(1'b0, 1'b1);
        issue_cmd(MODE_WRITE, 8'h00, 1'b1);
        set_pins(1'b1, 1'b0);
        issue_cmd(MODE_READ, 8'h00, 1'b0);
        hold_pins = 1'b0;
        issue_cmd(MODE_RESTART, 8'h00, 1'b0);
        issue_cmd(MODE_WRITE, 8'hA5, 1'b0);
        set_pins(1'b0, 1'b0);
        issue_cmd(MODE_READ, 8'hFF, 1'b1);
        // unknown modes leave the sequencer idle
        issue_cmd(3'd5, 8'h12, 1'b0);
        issue_cmd(3'd6, 8'h34, 1'b1);
        issue_cmd(3'd7, 8'h56, 1'b0);
        set_pins(1'b1, 1'b1);
        issue_cmd(MODE_STOP, 8'h00, 1'b0);
        set_pins(1'b1, 1'b0);
        issue_cmd(MODE_STOP, 8'h00, 1'b0);
        set_pins(1'b0, 1'b0);
        issue_cmd(MODE_STOP, 8'h00, 1'b0);
        hold_pins = 1'b0;

        // zero slot length acts as one
        write_slot(16'd0);
        issue_cmd(MODE_START, 8'h00, 1'b0);
        issue_cmd(MODE_WRITE, 8'h80, 1'b0);
        issue_cmd(MODE_READ, 8'h00, 1'b1);
        issue_cmd(MODE_STOP, 8'h00, 1'b0);

        // Random frames over several slot lengths
        random_phase(16'($urandom_range(2, 3)), 4);
        random_phase(16'd1, 6);
        gaps_on = 1'b0;
        random_phase(16'd0, 6);

        drain_results();
        repeat (8) @(posedge i_clk);

        $display("ran %0d ticks, %0d commands taken (start %0d restart %0d stop %0d",
                 sb.n_ticks, sb.n_done, sb.cmd_taken[0], sb.cmd_taken[1],
                 sb.cmd_taken[2]);
        $display("  write %0d read %0d), %0d slot settings, %0d beats checked, %0d errors",
                 sb.cmd_taken[3], sb.cmd_taken[4], cfg_writes, sb.n_beats, sb.n_errors);
        if (sb.n_errors == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
